FILE: rtl/bids_pkg.sv
// shared types and constants of the bilinear downscaler
`timescale 1ns / 1ps
`default_nettype none
package bids_pkg;
	localparam int CH_W      = 16;
	localparam int PIX_W     = 4 * CH_W;
	localparam int WGT_W     = 17;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;
	localparam int OUT_COL_W = 12;
	localparam int OUT_ROW_W = 11;
	localparam int SRC_W_W   = 15;
	localparam int SRC_H_W   = 14;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

	typedef struct packed {
		logic recalc;
		logic clear;
		logic adv;
	} ax_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [1:0]       n;
		logic             same0;
		logic             same1;
		logic [WGT_W-1:0] w0;
		logic [WGT_W-1:0] w1;
	} ax_stat_t;

	typedef struct packed {
		logic recalc;
		logic cfg_we;
		logic take;
		logic look;
		logic mix1;
		logic mix2;
		logic next;
		logic fin;
		logic adv2;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic drop;
		logic nout;
		logic last;
		logic adv2;
	} dp_stat_t;
endpackage
`default_nettype wire

FILE: rtl/bilinear_image_downscaler_core.sv
// top level of the streaming bilinear image downscaler
// usage
//   source rgba pixels enter in raster order on the in_ channel (valid/ready),
//   start_of_frame on the first pixel of a frame restarts all position counters
//   output pixels of the fixed output frame leave on the out_ channel with
//   their column and row, last_of_run on the final result of an item and
//   end_of_frame on the bottom-right output pixel
//   source_width and source_height are written on the cfg_ channel between items
// timing
//   an item that causes no result passes the look and fin states, and adv2 when a
//   tracker moves by two; each result adds mix1, mix2 and out plus any stall
//   an item past the last source row is dropped
//   the first result passes the look, mix1 and mix2 states before out_valid rises
//   the cost per result is set by the two-stage multiply of the mixer
//   after reset and after every register write the step constants are rebuilt
//   by a reciprocal multiply in 4 passes; in_ready stays low until they are done
// stalls
//   a result is held on the outputs until out_ready; no further item is taken
//   until every result of the current one has left
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_downscaler_core #(
	parameter int OUT_WIDTH        = 4096,
	parameter int OUT_HEIGHT       = 2048,
	parameter int MAX_SOURCE_WIDTH = 16384
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [bids_pkg::CH_W-1:0]       in_red,
	input  wire logic [bids_pkg::CH_W-1:0]       in_green,
	input  wire logic [bids_pkg::CH_W-1:0]       in_blue,
	input  wire logic [bids_pkg::CH_W-1:0]       in_alpha,
	input  wire logic                            start_of_frame,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [bids_pkg::CH_W-1:0]       out_red,
	output logic      [bids_pkg::CH_W-1:0]       out_green,
	output logic      [bids_pkg::CH_W-1:0]       out_blue,
	output logic      [bids_pkg::CH_W-1:0]       out_alpha,
	output logic      [bids_pkg::OUT_COL_W-1:0]  out_col,
	output logic      [bids_pkg::OUT_ROW_W-1:0]  out_row,
	output logic                                 last_of_run,
	output logic                                 end_of_frame,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bids_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bids_pkg::SRC_W_W-1:0]    cfg_data
);
	import bids_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bids_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bids_dp #(
		.OUT_WIDTH        (OUT_WIDTH),
		.OUT_HEIGHT       (OUT_HEIGHT),
		.MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_red         (in_red),
		.in_green       (in_green),
		.in_blue        (in_blue),
		.in_alpha       (in_alpha),
		.start_of_frame (start_of_frame),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.out_alpha      (out_alpha),
		.out_col        (out_col),
		.out_row        (out_row),
		.last_of_run    (last_of_run),
		.end_of_frame   (end_of_frame)
	);
endmodule
`default_nettype wire

FILE: rtl/bids_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bids_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bids_axis.sv
// axis position tracker: source index, remainder and weight of the next output line
`timescale 1ns / 1ps
`default_nettype none
module bids_axis #(
	parameter int OUT_SIZE = 4096,
	parameter int SW       = 17,
	parameter int KW       = $clog2(OUT_SIZE + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [SW-1:0]      size,
	input  wire logic [SW-1:0]      target,
	input  wire bids_pkg::ax_cmd_t  cmd,
	output bids_pkg::ax_stat_t      stat,
	output logic      [KW-1:0]      pos
);
	import bids_pkg::*;

	localparam int DEN  = OUT_SIZE - 1;
	localparam int DW   = $clog2(DEN + 1);
	localparam int HALF = DEN / 2;
	localparam int NB   = (KW + SW > DW + 17) ? KW + SW : DW + 17;
	localparam int LW   = $clog2(DEN);
	localparam int SH   = NB + LW;
	localparam int MW   = NB + 2;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	logic [KW-1:0]    k_q;
	logic [SW-1:0]    lo_q, q_q;
	logic [DW-1:0]    rem_q, wres_q, r_q, wr_q;
	logic [WGT_W-1:0] w_q, wq_q;

	logic             busy_q;
	logic [1:0]       phase_q;
	logic             step_q;
	logic [NB-1:0]    num_q;
	logic [NB+MW-1:0] mprod_q;

	logic [DW:0]      rsum, wsum;
	logic             wrap, wc;
	logic [DW-1:0]    rem_n, wres_n, drem;
	logic [NB-1:0]    quo;
	logic [SW-1:0]    lo_n, hi0, hi1;
	logic [SW:0]      lo0p, lo1p;
	logic [WGT_W:0]   wtmp;
	logic [WGT_W-1:0] w_n;
	logic [KW:0]      k0x, k1x;
	logic             hit0, hit1;
	logic [KW+SW-1:0] prod;

	always_comb begin
		rsum   = {1'b0, rem_q} + {1'b0, r_q};
		wrap   = rsum >= (DW+1)'(DEN);
		rem_n  = wrap ? DW'(rsum - (DW+1)'(DEN)) : rsum[DW-1:0];
		lo_n   = lo_q + q_q + SW'(wrap);
		wsum   = {1'b0, wres_q} + {1'b0, wr_q};
		wc     = wsum >= (DW+1)'(DEN);
		wres_n = wc ? DW'(wsum - (DW+1)'(DEN)) : wsum[DW-1:0];
		wtmp   = {1'b0, w_q} + {1'b0, wq_q} + (WGT_W+1)'(wc);
		w_n    = wrap ? WGT_W'(wtmp - {1'b0, WGT_ONE}) : wtmp[WGT_W-1:0];
		lo0p   = {1'b0, lo_q} + (SW+1)'(1);
		lo1p   = {1'b0, lo_n} + (SW+1)'(1);
		hi0    = (lo0p < {1'b0, size}) ? lo0p[SW-1:0] : size - SW'(1);
		hi1    = (lo1p < {1'b0, size}) ? lo1p[SW-1:0] : size - SW'(1);
		k0x    = {1'b0, k_q};
		k1x    = k0x + (KW+1)'(1);
		hit0   = (k0x < (KW+1)'(OUT_SIZE)) && (hi0 == target);
		hit1   = hit0 && (k1x < (KW+1)'(OUT_SIZE)) && (hi1 == target);
		quo    = NB'(mprod_q >> SH);
		drem   = num_q[DW-1:0] - DW'(quo[DW-1:0] * DW'(DEN));
		prod   = KW'(k_q) * (size - SW'(1));
	end

	always_comb begin
		stat.busy  = busy_q;
		stat.n     = hit1 ? 2'd2 : (hit0 ? 2'd1 : 2'd0);
		stat.same0 = lo_q == target;
		stat.same1 = lo_n == target;
		stat.w0    = w_q;
		stat.w1    = w_n;
		pos        = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			lo_q    <= '0;
			rem_q   <= '0;
			w_q     <= '0;
			wres_q  <= '0;
			q_q     <= '0;
			r_q     <= '0;
			wq_q    <= '0;
			wr_q    <= '0;
			busy_q  <= 1'b0;
			phase_q <= '0;
			step_q  <= 1'b0;
			num_q   <= '0;
			mprod_q <= '0;
		end else if (cmd.recalc) begin
			busy_q  <= 1'b1;
			phase_q <= '0;
			step_q  <= 1'b0;
			num_q   <= NB'(size - SW'(1));
		end else if (busy_q) begin
			if (!step_q) begin
				mprod_q <= num_q * RECIP;
				step_q  <= 1'b1;
			end else begin
				step_q  <= 1'b0;
				phase_q <= phase_q + 2'd1;
				case (phase_q)
					2'd0: begin
						q_q   <= SW'(quo);
						r_q   <= drem;
						num_q <= NB'({drem, 16'b0});
					end
					2'd1: begin
						wq_q  <= WGT_W'(quo);
						wr_q  <= drem;
						num_q <= NB'(prod);
					end
					2'd2: begin
						lo_q  <= SW'(quo);
						rem_q <= drem;
						num_q <= NB'({drem, 16'b0}) + NB'(HALF);
					end
					default: begin
						w_q    <= WGT_W'(quo);
						wres_q <= drem;
						busy_q <= 1'b0;
					end
				endcase
			end
		end else if (cmd.clear) begin
			k_q    <= '0;
			lo_q   <= '0;
			rem_q  <= '0;
			w_q    <= '0;
			wres_q <= DW'(HALF);
		end else if (cmd.adv) begin
			k_q    <= k_q + KW'(1);
			lo_q   <= lo_n;
			rem_q  <= rem_n;
			w_q    <= w_n;
			wres_q <= wres_n;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/bids_dp.sv
// datapath: config registers, counters, line store, axis trackers and mixer
`timescale 1ns / 1ps
`default_nettype none
module bids_dp #(
	parameter int OUT_WIDTH        = 4096,
	parameter int OUT_HEIGHT       = 2048,
	parameter int MAX_SOURCE_WIDTH = 16384
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bids_pkg::dp_cmd_t               cmd,
	output bids_pkg::dp_stat_t                   stat,
	input  wire logic [bids_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bids_pkg::SRC_W_W-1:0]    cfg_data,
	input  wire logic [bids_pkg::CH_W-1:0]       in_red,
	input  wire logic [bids_pkg::CH_W-1:0]       in_green,
	input  wire logic [bids_pkg::CH_W-1:0]       in_blue,
	input  wire logic [bids_pkg::CH_W-1:0]       in_alpha,
	input  wire logic                            start_of_frame,
	output logic      [bids_pkg::CH_W-1:0]       out_red,
	output logic      [bids_pkg::CH_W-1:0]       out_green,
	output logic      [bids_pkg::CH_W-1:0]       out_blue,
	output logic      [bids_pkg::CH_W-1:0]       out_alpha,
	output logic      [bids_pkg::OUT_COL_W-1:0]  out_col,
	output logic      [bids_pkg::OUT_ROW_W-1:0]  out_row,
	output logic                                 last_of_run,
	output logic                                 end_of_frame
);
	import bids_pkg::*;

	localparam int CW   = $clog2(MAX_SOURCE_WIDTH);
	localparam int SWC  = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int CMPW = (SRC_W_W > SWC) ? SRC_W_W : SWC;
	localparam int KWC  = $clog2(OUT_WIDTH + 1);
	localparam int KWR  = $clog2(OUT_HEIGHT + 1);

	logic [SRC_W_W-1:0] src_w_q;
	logic [SRC_H_W-1:0] src_h_q;
	logic [SWC-1:0]     ew;
	logic [SRC_H_W-1:0] eh;
	logic [CMPW-1:0]    wide;

	logic [CW-1:0]      c_q;
	logic [SRC_H_W-1:0] r_q;
	logic [PIX_W-1:0]   cur_q, held_cur_q, held_prev_q, upper;
	logic [1:0]         ncols_q, nrows_q;
	logic               row_end_q, a_q, b_q;

	ax_cmd_t            ccmd, rcmd;
	ax_stat_t           cst, rst;
	logic [KWC-1:0]     cpos;
	logic [KWR-1:0]     rpos;

	logic [WGT_W-1:0]   wx, wy;
	logic               xsame, ysame, last_a, last_b;
	logic [PIX_W-1:0]   p00, p01, p10, p11;
	logic [KWC:0]       colx;
	logic [KWR:0]       rowx;

	logic [31:0]        top_s1 [4];
	logic [31:0]        bot_s1 [4];
	logic [WGT_W-1:0]   wy_s1;
	logic [OUT_COL_W-1:0] col_s1;
	logic [OUT_ROW_W-1:0] row_s1;
	logic               last_s1, eof_s1;
	logic [CH_W-1:0]    res_q [4];

	always_comb begin
		wide = CMPW'(src_w_q);
		if (wide < CMPW'(OUT_WIDTH + 1)) begin
			ew = SWC'(OUT_WIDTH + 1);
		end else if (wide > CMPW'(MAX_SOURCE_WIDTH)) begin
			ew = SWC'(MAX_SOURCE_WIDTH);
		end else begin
			ew = SWC'(wide);
		end
		eh = (src_h_q < SRC_H_W'(OUT_HEIGHT + 1)) ? SRC_H_W'(OUT_HEIGHT + 1) : src_h_q;
	end

	always_comb begin
		ccmd.recalc = cmd.recalc;
		rcmd.recalc = cmd.recalc;
		ccmd.clear  = (cmd.take && start_of_frame) || (cmd.fin && row_end_q);
		rcmd.clear  = cmd.take && start_of_frame;
		ccmd.adv    = !row_end_q && ((cmd.fin && ncols_q != 2'd0) ||
			(cmd.adv2 && ncols_q == 2'd2));
		rcmd.adv    = row_end_q && ((cmd.fin && nrows_q != 2'd0) ||
			(cmd.adv2 && nrows_q == 2'd2));
	end

	bids_axis #(.OUT_SIZE(OUT_WIDTH), .SW(SWC), .KW(KWC)) u_col (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (ew),
		.target (SWC'(c_q)),
		.cmd    (ccmd),
		.stat   (cst),
		.pos    (cpos)
	);

	bids_axis #(.OUT_SIZE(OUT_HEIGHT), .SW(SRC_H_W), .KW(KWR)) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (eh),
		.target (r_q),
		.cmd    (rcmd),
		.stat   (rst),
		.pos    (rpos)
	);

	bids_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SOURCE_WIDTH), .AW(CW)) u_line (
		.clk   (clk),
		.we    (cmd.fin),
		.waddr (c_q),
		.wdata (cur_q),
		.re    (cmd.look),
		.raddr (c_q),
		.rdata (upper)
	);

	always_comb begin
		last_a    = !(ncols_q == 2'd2 && !a_q);
		last_b    = !(nrows_q == 2'd2 && !b_q);
		stat.busy = cst.busy || rst.busy;
		stat.drop = r_q >= eh;
		stat.nout = (cst.n != 2'd0) && (rst.n != 2'd0);
		stat.last = last_a && last_b;
		stat.adv2 = row_end_q ? (nrows_q == 2'd2) : (ncols_q == 2'd2);
	end

	always_comb begin
		wx    = a_q ? cst.w1 : cst.w0;
		xsame = a_q ? cst.same1 : cst.same0;
		wy    = b_q ? rst.w1 : rst.w0;
		ysame = b_q ? rst.same1 : rst.same0;
		p11   = cur_q;
		p01   = xsame ? cur_q : held_cur_q;
		p10   = ysame ? cur_q : upper;
		p00   = ysame ? (xsame ? cur_q : held_cur_q) : (xsame ? upper : held_prev_q);
		colx  = {1'b0, cpos} + (KWC+1)'(a_q);
		rowx  = {1'b0, rpos} + (KWR+1)'(b_q);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= SRC_W_W'(8192);
			src_h_q     <= SRC_H_W'(4096);
			c_q         <= '0;
			r_q         <= '0;
			ncols_q     <= '0;
			nrows_q     <= '0;
			row_end_q   <= 1'b0;
			a_q         <= 1'b0;
			b_q         <= 1'b0;
			held_cur_q  <= '0;
			held_prev_q <= '0;
		end else begin
			if (cmd.cfg_we) begin
				if (cfg_index == REG_SOURCE_WIDTH) begin
					src_w_q <= cfg_data;
				end else if (cfg_index == REG_SOURCE_HEIGHT) begin
					src_h_q <= cfg_data[SRC_H_W-1:0];
				end
			end
			if (cmd.take && start_of_frame) begin
				c_q <= '0;
				r_q <= '0;
			end
			if (cmd.look) begin
				ncols_q   <= cst.n;
				nrows_q   <= rst.n;
				row_end_q <= (SWC'(c_q) + SWC'(1)) >= ew;
				a_q       <= 1'b0;
				b_q       <= 1'b0;
			end
			if (cmd.next) begin
				if (!last_a) begin
					a_q <= 1'b1;
				end else begin
					a_q <= 1'b0;
					b_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				held_prev_q <= upper;
				held_cur_q  <= cur_q;
				if (row_end_q) begin
					c_q <= '0;
					r_q <= r_q + SRC_H_W'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_q <= {in_alpha, in_blue, in_green, in_red};
		end
		if (cmd.mix1) begin
			for (int ch = 0; ch < 4; ch++) begin
				top_s1[ch] <= 32'(p00[CH_W*ch +: CH_W]) * 32'(WGT_ONE - wx) +
					32'(p10[CH_W*ch +: CH_W]) * 32'(wx);
				bot_s1[ch] <= 32'(p01[CH_W*ch +: CH_W]) * 32'(WGT_ONE - wx) +
					32'(p11[CH_W*ch +: CH_W]) * 32'(wx);
			end
			wy_s1   <= wy;
			col_s1  <= OUT_COL_W'(colx);
			row_s1  <= OUT_ROW_W'(rowx);
			last_s1 <= last_a && last_b;
			eof_s1  <= (colx == (KWC+1)'(OUT_WIDTH - 1)) &&
				(rowx == (KWR+1)'(OUT_HEIGHT - 1));
		end
		if (cmd.mix2) begin
			for (int ch = 0; ch < 4; ch++) begin
				res_q[ch] <= CH_W'((48'(top_s1[ch]) * 48'(WGT_ONE - wy_s1) +
					48'(bot_s1[ch]) * 48'(wy_s1) + 48'h0000_8000_0000) >> 32);
			end
			out_col      <= col_s1;
			out_row      <= row_s1;
			last_of_run  <= last_s1;
			end_of_frame <= eof_s1;
		end
	end

	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];
	assign out_alpha = res_q[3];
endmodule
`default_nettype wire

FILE: rtl/bids_ctrl.sv
// controller state machine of the bilinear downscaler
`timescale 1ns / 1ps
`default_nettype none
module bids_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	output bids_pkg::dp_cmd_t        cmd,
	input  wire bids_pkg::dp_stat_t  stat
);
	import bids_pkg::*;

	typedef enum logic [7:0] {
		ST_RECALC = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_LOOK   = 8'b0000_0100,
		ST_MIX1   = 8'b0000_1000,
		ST_MIX2   = 8'b0001_0000,
		ST_OUT    = 8'b0010_0000,
		ST_FIN    = 8'b0100_0000,
		ST_ADV2   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   stale_q;

	always_comb begin
		cfg_ready = state_q == ST_IDLE;
		in_ready  = (state_q == ST_IDLE) && !stale_q && !cfg_valid;
		out_valid = state_q == ST_OUT;
		cmd       = '0;
		cmd.cfg_we = cfg_valid && cfg_ready;
		state_d   = state_q;
		case (state_q)
			ST_RECALC: begin
				if (!stat.busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (stale_q) begin
					cmd.recalc = 1'b1;
					state_d    = ST_RECALC;
				end else if (in_valid && in_ready) begin
					cmd.take = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.drop) begin
					state_d = ST_IDLE;
				end else begin
					cmd.look = 1'b1;
					state_d  = stat.nout ? ST_MIX1 : ST_FIN;
				end
			end
			ST_MIX1: begin
				cmd.mix1 = 1'b1;
				state_d  = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.mix2 = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					if (stat.last) begin
						state_d = ST_FIN;
					end else begin
						cmd.next = 1'b1;
						state_d  = ST_MIX1;
					end
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = stat.adv2 ? ST_ADV2 : ST_IDLE;
			end
			ST_ADV2: begin
				cmd.adv2 = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stale_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cmd.cfg_we) begin
				stale_q <= 1'b1;
			end else if (cmd.recalc) begin
				stale_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !stat.busy)
		else $error("item taken while step constants are being recomputed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !in_ready)
		else $error("item taken straight after a register write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV2) |-> $past(state_q == ST_FIN))
		else $error("second advance without a finishing step");
endmodule
`default_nettype wire
